@@ sv/kmeans_document_clustering_unit_macros.svh @@
// Assertion macros for the k-means clustering unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef KMEANS_DOCUMENT_CLUSTERING_UNIT_MACROS_SVH
`define KMEANS_DOCUMENT_CLUSTERING_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define KMDC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kmdc same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define KMDC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kmdc next-cycle check failed");

`endif

@@ sv/kmdc_pkg.sv @@
// Shared types and constants of the k-means clustering unit.
// No dependencies; imported by the divider and the top level.
`timescale 1ns / 1ps

package kmdc_pkg;

	localparam int MAX_DOCS     = 1024;
	localparam int MAX_CABINETS = 16;
	localparam int MAX_SUBJECTS = 16;

	localparam int DOC_W   = 10;
	localparam int CAB_W   = 4;
	localparam int SUBJ_W  = 4;
	localparam int SCORE_W = 16;
	localparam int SUM_W   = 26;
	localparam int CNT_W   = 11;
	localparam int SQ_W    = 32;
	localparam int DIST_W  = 36;
	localparam int PASS_W  = 16;
	localparam int DIV_CW  = 5;

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_RUN  = 2'd1,
		FUNC_READ = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_CABINETS  = 2'd0,
		REG_SUBJECTS  = 2'd1,
		REG_DOCUMENTS = 2'd2,
		REG_ITER_LIM  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ sv/kmeans_document_clustering_unit.sv @@
// Channel   | Signals                                         | Transfer
// ----------+-------------------------------------------------+--------------------------
// command   | start, busy, func, doc_index, subject_index, score | start && !busy
// result    | done, cabinet, pass_count, converged            | done (one cycle each)
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data       | cfg_valid && cfg_ready
// A load leaves busy low; a read passes through S_RD_OUT before raising done.
// A run writes the initial assignment (one document per cycle), then each pass
// accumulates the per-cabinet sums, computes the means in the shared divider
// and reassigns each document to its nearest mean in the shared squaring datapath.
// Reset clears control state; the score and assignment memories are not cleared.
// Results cannot be stalled; cfg_ready is always high.
// Depends on kmdc_pkg, kmdc_div and the macros header.
`timescale 1ns / 1ps
`include "kmeans_document_clustering_unit_macros.svh"

module kmeans_document_clustering_unit
	import kmdc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [DOC_W-1:0]   doc_index,
	input  logic [SUBJ_W-1:0]  subject_index,
	input  logic [SCORE_W-1:0] score,
	output logic               done,
	output logic [CAB_W-1:0]   cabinet,
	output logic [PASS_W-1:0]  pass_count,
	output logic               converged,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	typedef enum logic [19:0] {
		S_IDLE   = 20'h00001,
		S_RD_OUT = 20'h00002,
		S_INIT   = 20'h00004,
		S_PSTART = 20'h00008,
		S_A_ASG  = 20'h00010,
		S_A_ASGW = 20'h00020,
		S_A_RD   = 20'h00040,
		S_A_WR   = 20'h00080,
		S_M_RD   = 20'h00100,
		S_M_DIV  = 20'h00200,
		S_M_WAIT = 20'h00400,
		S_D_ASG  = 20'h00800,
		S_D_ASGW = 20'h01000,
		S_D_RD   = 20'h02000,
		S_D_SQ   = 20'h04000,
		S_D_AC   = 20'h08000,
		S_D_CMP  = 20'h10000,
		S_D_UPD  = 20'h20000,
		S_PEND   = 20'h40000,
		S_DONE   = 20'h80000
	} state_t;

	localparam int SIDX_W = CAB_W + SUBJ_W;
	localparam int SADR_W = DOC_W + SUBJ_W;
	localparam int NSUM   = MAX_CABINETS * MAX_SUBJECTS;

	// Configuration registers.
	logic [4:0]        cab_cnt_q;
	logic [4:0]        subj_cnt_q;
	logic [CNT_W-1:0]  doc_cnt_q;
	logic [PASS_W-1:0] iter_lim_q;

	// Run parameters, fixed for the length of a run.
	logic [4:0]        nc_q;
	logic [4:0]        ns_q;
	logic [CNT_W-1:0]  nd_q;
	logic [PASS_W-1:0] lim_q;

	state_t            state_q;
	logic [DOC_W-1:0]  d_q;
	logic [CAB_W-1:0]  c_q;
	logic [SUBJ_W-1:0] s_q;
	logic [CAB_W-1:0]  ic_q;
	logic [CAB_W-1:0]  a_q;
	logic [CAB_W-1:0]  best_c_q;
	logic [DIST_W-1:0] best_q;
	logic [DIST_W-1:0] dist_q;
	logic [SQ_W-1:0]   prod_q;
	logic [PASS_W-1:0] pass_q;
	logic              conv_q;
	logic              changed_q;
	logic              rd_ok_q;
	logic              done_q;
	logic [CAB_W-1:0]  cab_q;
	logic [CNT_W-1:0]  cnt_q [MAX_CABINETS];
	logic [NSUM-1:0]   sum_vld_q;

	// Memories.
	logic [SCORE_W-1:0] score_mem [MAX_DOCS*MAX_SUBJECTS];
	logic [CAB_W-1:0]   asg_mem [MAX_DOCS];
	logic [SUM_W-1:0]   sum_mem [NSUM];
	logic [SCORE_W-1:0] mean_mem [NSUM];
	logic [SCORE_W-1:0] score_rd_q;
	logic [CAB_W-1:0]   asg_rd_q;
	logic [SUM_W-1:0]   sum_rd_q;
	logic               sum_vld_rd_q;
	logic [SCORE_W-1:0] mean_rd_q;

	logic               accept;
	logic               last_d;
	logic               last_c;
	logic               last_s;
	logic               last_ic;
	logic [DOC_W-1:0]   asg_raddr;
	logic               asg_we;
	logic [CAB_W-1:0]   asg_wdata;
	logic [SIDX_W-1:0]  sum_addr;
	logic [SIDX_W-1:0]  cs_addr;
	logic [SADR_W-1:0]  score_raddr;
	logic [SUM_W-1:0]   sum_cur;
	logic [SCORE_W-1:0] diff;
	logic [PASS_W-1:0]  pass_nxt;
	logic [CNT_W-1:0]   nd_clamp;
	logic               read_ok;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	function automatic logic [4:0] clamp16(input logic [4:0] v);
		logic [4:0] r;
		r = v;
		if (v == 5'd0) begin
			r = 5'd1;
		end else if (v > 5'(MAX_CABINETS)) begin
			r = 5'(MAX_CABINETS);
		end
		return r;
	endfunction

	always_comb begin
		nd_clamp = doc_cnt_q;
		if (doc_cnt_q == '0) begin
			nd_clamp = CNT_W'(1);
		end else if (doc_cnt_q > CNT_W'(MAX_DOCS)) begin
			nd_clamp = CNT_W'(MAX_DOCS);
		end
	end

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign read_ok   = ({1'b0, doc_index} < nd_clamp);

	assign last_d  = ({1'b0, d_q} == (nd_q - CNT_W'(1)));
	assign last_c  = ({1'b0, c_q} == (nc_q - 5'd1));
	assign last_s  = ({1'b0, s_q} == (ns_q - 5'd1));
	assign last_ic = ({1'b0, ic_q} == (nc_q - 5'd1));

	assign cs_addr     = {c_q, s_q};
	assign score_raddr = {d_q, s_q};
	assign asg_raddr   = (state_q == S_IDLE) ? doc_index : d_q;
	assign sum_addr    = (state_q == S_A_RD || state_q == S_A_WR) ? {a_q, s_q} : cs_addr;
	assign sum_cur     = sum_vld_rd_q ? sum_rd_q : '0;
	assign diff        = (score_rd_q >= mean_rd_q) ? (score_rd_q - mean_rd_q)
	                                               : (mean_rd_q - score_rd_q);
	assign pass_nxt    = pass_q + 1'b1;

	always_comb begin
		asg_we    = 1'b0;
		asg_wdata = ic_q;
		if (state_q == S_INIT) begin
			asg_we = 1'b1;
		end else if (state_q == S_D_UPD && best_c_q != a_q) begin
			asg_we    = 1'b1;
			asg_wdata = best_c_q;
		end
	end

	assign div_req.start    = (state_q == S_M_DIV);
	assign div_req.dividend = sum_cur;
	assign div_req.divisor  = cnt_q[c_q];

	kmdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cab_cnt_q  <= 5'd1;
			subj_cnt_q <= 5'd1;
			doc_cnt_q  <= CNT_W'(1);
			iter_lim_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CABINETS:  cab_cnt_q  <= cfg_data[4:0];
				REG_SUBJECTS:  subj_cnt_q <= cfg_data[4:0];
				REG_DOCUMENTS: doc_cnt_q  <= cfg_data[CNT_W-1:0];
				REG_ITER_LIM:  iter_lim_q <= cfg_data[PASS_W-1:0];
				default: ;
			endcase
		end
	end

	// Memory ports.
	always_ff @(posedge clk) begin
		if (accept && func_t'(func) == FUNC_LOAD) begin
			score_mem[{doc_index, subject_index}] <= score;
		end
		score_rd_q <= score_mem[score_raddr];
	end

	always_ff @(posedge clk) begin
		if (asg_we) begin
			asg_mem[d_q] <= asg_wdata;
		end
		asg_rd_q <= asg_mem[asg_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_A_WR) begin
			sum_mem[sum_addr] <= sum_cur + SUM_W'(score_rd_q);
		end
		sum_rd_q     <= sum_mem[sum_addr];
		sum_vld_rd_q <= sum_vld_q[sum_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_M_WAIT && div_rsp.done) begin
			mean_mem[cs_addr] <= (cnt_q[c_q] == '0) ? '0 : div_rsp.quotient[SCORE_W-1:0];
		end
		mean_rd_q <= mean_mem[cs_addr];
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		prod_q <= diff * diff;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			nc_q      <= 5'd1;
			ns_q      <= 5'd1;
			nd_q      <= CNT_W'(1);
			lim_q     <= PASS_W'(1);
			d_q       <= '0;
			c_q       <= '0;
			s_q       <= '0;
			ic_q      <= '0;
			a_q       <= '0;
			best_c_q  <= '0;
			best_q    <= '0;
			dist_q    <= '0;
			pass_q    <= '0;
			conv_q    <= 1'b0;
			changed_q <= 1'b0;
			rd_ok_q   <= 1'b0;
			done_q    <= 1'b0;
			cab_q     <= '0;
			sum_vld_q <= '0;
			for (int i = 0; i < MAX_CABINETS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && func_t'(func) == FUNC_RUN) begin
						nc_q    <= clamp16(cab_cnt_q);
						ns_q    <= clamp16(subj_cnt_q);
						nd_q    <= nd_clamp;
						lim_q   <= (iter_lim_q == '0) ? PASS_W'(1) : iter_lim_q;
						d_q     <= '0;
						ic_q    <= '0;
						pass_q  <= '0;
						state_q <= S_INIT;
					end else if (accept && func_t'(func) == FUNC_READ) begin
						rd_ok_q <= read_ok;
						state_q <= S_RD_OUT;
					end
				end
				S_RD_OUT: begin
					cab_q   <= rd_ok_q ? asg_rd_q : '0;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_INIT: begin
					ic_q <= last_ic ? '0 : ic_q + 1'b1;
					if (last_d) begin
						state_q <= S_PSTART;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
				S_PSTART: begin
					sum_vld_q <= '0;
					for (int i = 0; i < MAX_CABINETS; i++) begin
						cnt_q[i] <= '0;
					end
					changed_q <= 1'b0;
					d_q       <= '0;
					state_q   <= S_A_ASG;
				end
				S_A_ASG: begin
					state_q <= S_A_ASGW;
				end
				S_A_ASGW: begin
					a_q             <= asg_rd_q;
					cnt_q[asg_rd_q] <= cnt_q[asg_rd_q] + 1'b1;
					s_q             <= '0;
					state_q         <= S_A_RD;
				end
				S_A_RD: begin
					state_q <= S_A_WR;
				end
				S_A_WR: begin
					sum_vld_q[sum_addr] <= 1'b1;
					if (!last_s) begin
						s_q     <= s_q + 1'b1;
						state_q <= S_A_RD;
					end else if (!last_d) begin
						d_q     <= d_q + 1'b1;
						state_q <= S_A_ASG;
					end else begin
						c_q     <= '0;
						s_q     <= '0;
						state_q <= S_M_RD;
					end
				end
				S_M_RD: begin
					state_q <= S_M_DIV;
				end
				S_M_DIV: begin
					state_q <= S_M_WAIT;
				end
				S_M_WAIT: begin
					if (div_rsp.done) begin
						if (!last_s) begin
							s_q     <= s_q + 1'b1;
							state_q <= S_M_RD;
						end else if (!last_c) begin
							c_q     <= c_q + 1'b1;
							s_q     <= '0;
							state_q <= S_M_RD;
						end else begin
							d_q     <= '0;
							state_q <= S_D_ASG;
						end
					end
				end
				S_D_ASG: begin
					c_q     <= '0;
					s_q     <= '0;
					state_q <= S_D_ASGW;
				end
				S_D_ASGW: begin
					a_q     <= asg_rd_q;
					dist_q  <= '0;
					state_q <= S_D_RD;
				end
				S_D_RD: begin
					state_q <= S_D_SQ;
				end
				S_D_SQ: begin
					state_q <= S_D_AC;
				end
				S_D_AC: begin
					dist_q <= dist_q + DIST_W'(prod_q);
					if (last_s) begin
						state_q <= S_D_CMP;
					end else begin
						s_q     <= s_q + 1'b1;
						state_q <= S_D_RD;
					end
				end
				S_D_CMP: begin
					// Strict compare keeps the lowest cabinet index on a tie.
					if (c_q == '0 || dist_q < best_q) begin
						best_q   <= dist_q;
						best_c_q <= c_q;
					end
					dist_q <= '0;
					s_q    <= '0;
					if (last_c) begin
						state_q <= S_D_UPD;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_D_RD;
					end
				end
				S_D_UPD: begin
					if (best_c_q != a_q) begin
						changed_q <= 1'b1;
					end
					if (last_d) begin
						state_q <= S_PEND;
					end else begin
						d_q     <= d_q + 1'b1;
						state_q <= S_D_ASG;
					end
				end
				S_PEND: begin
					pass_q <= pass_nxt;
					if (!changed_q || pass_nxt >= lim_q) begin
						conv_q  <= !changed_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_PSTART;
					end
				end
				S_DONE: begin
					cab_q   <= '0;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign cabinet    = cab_q;
	assign pass_count = pass_q;
	assign converged  = conv_q;

	`KMDC_ASSERT_IMP(a_done_after_work, done, $past(busy))
	`KMDC_ASSERT_IMP(a_busy_ends_in_result, $fell(busy), done)
	`KMDC_ASSERT_IMP(a_unconverged_hits_limit, done && !converged && pass_count != '0,
		pass_count == lim_q)
	`KMDC_ASSERT_NXT(a_load_stays_idle, accept && func_t'(func) == FUNC_LOAD, !busy)

endmodule

@@ sv/kmdc_div.sv @@
// Restoring divider, one quotient bit per cycle, for the cluster means.
// Depends on kmdc_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module kmdc_div
	import kmdc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(SUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// The remainder stays below the divisor, so it fits in CNT_W bits.
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
